// ----- rtl/core/dsp_pkg.sv -----
// ----------------------------------------------------------------------------
// dsp_pkg
// Shared types and constants of the decimating sample packetizer.
// ----------------------------------------------------------------------------
package dsp_pkg;

    localparam logic [15:0] HEADER_WORD = 16'hAAAA;
    localparam logic [7:0]  FOOTER_BYTE = 8'h55;
    localparam int unsigned SUM_W       = 28;
    localparam int unsigned DIV_W       = 5;

    // Register indexes on the configuration port
    typedef enum logic [2:0] {
        REG_ECG_A_DIV  = 3'd0,
        REG_ECG_B_DIV  = 3'd1,
        REG_ACCEL_EN   = 3'd2,
        REG_BATTERY_EN = 3'd3,
        REG_LEAD_EN    = 3'd4,
        REG_DIGITAL_EN = 3'd5
    } reg_idx_t;

    // Request from the sequencer to the divider
    typedef struct packed {
        logic                    start;
        logic signed [SUM_W-1:0] dividend;
        logic [DIV_W-1:0]        divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [23:0] quotient;
    } div_rsp_t;

endpackage

// ----- rtl/core/dsp_ram.sv -----
// ----------------------------------------------------------------------------
// dsp_ram
// Generic single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module dsp_ram #(
    parameter int unsigned WIDTH = 28,
    parameter int unsigned DEPTH = 10
) (
    input  logic                                           clk,
    input  logic                                           we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   addr,
    input  logic [WIDTH-1:0]                               wdata,
    output logic [WIDTH-1:0]                               rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ----- rtl/core/dsp_div.sv -----
// ----------------------------------------------------------------------------
// dsp_div
// Restoring signed divider, one quotient bit per cycle, truncation to zero.
// ----------------------------------------------------------------------------
module dsp_div
    import dsp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int unsigned CNT_W = $clog2(SUM_W + 1);

    logic [SUM_W-1:0] quo_reg, quo_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] dvs_reg;
    logic             neg_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg;
    logic             done_reg;
    logic [DIV_W:0]   trial;
    logic [SUM_W-1:0] mag;
    logic [SUM_W-1:0] signed_q;

    assign mag = req.dividend[SUM_W-1] ? SUM_W'(-req.dividend) : SUM_W'(req.dividend);
    assign trial = {rem_reg, quo_reg[SUM_W-1]};

    always_comb
    begin
        if (trial >= {1'b0, dvs_reg})
        begin
            rem_next = DIV_W'(trial - {1'b0, dvs_reg});
            quo_next = {quo_reg[SUM_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = DIV_W'(trial);
            quo_next = {quo_reg[SUM_W-2:0], 1'b0};
        end
        cnt_next = cnt_reg - CNT_W'(1);
    end

    assign signed_q     = neg_reg ? SUM_W'(-quo_reg) : quo_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = signed_q[23:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(SUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_next;
                if (cnt_next == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= mag;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
            neg_reg <= req.dividend[SUM_W-1];
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

endmodule

// ----- rtl/core/decimating_sample_packetizer.sv -----
// ----------------------------------------------------------------------------
// decimating_sample_packetizer
// Sums sample sets into per-channel slots and emits one packet per frame.
//
//  Channel  | Signals                                     | Direction
//  ---------+---------------------------------------------+----------
//  samples  | in_valid/in_ready, ecg_a .. pin_level       | in
//  chunks   | out_valid/out_ready, chunk, chunk_bytes,last| out
//  config   | psel/penable/pwrite/paddr/pwdata/prdata     | in/out
//
// After reset a clearing pass over all FRAME_SAMPLES slot addresses zeroes
// both slot RAMs while in_ready is held low. A sample that ends no frame
// passes accept, slot read and write back into the slot RAMs (one port
// each). A frame-end sample then sends its packet: each slot chunk passes
// address, RAM read, serial divider and hand-off; other chunks and skipped
// fields one state each. A stalled out_ready holds the sequencer.
// ----------------------------------------------------------------------------
module decimating_sample_packetizer
    import dsp_pkg::*;
#(
    parameter int unsigned FRAME_SAMPLES = 10
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [23:0]  ecg_a,
    input  logic signed [23:0]  ecg_b,
    input  logic [15:0]         accel_x,
    input  logic [15:0]         accel_y,
    input  logic [15:0]         accel_z,
    input  logic [15:0]         battery,
    input  logic [7:0]          lead_off_status,
    input  logic                pin_level,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [23:0]         chunk,
    output logic [1:0]          chunk_bytes,
    output logic                last
);

    localparam int unsigned AW = (FRAME_SAMPLES > 1) ? $clog2(FRAME_SAMPLES) : 1;
    localparam int unsigned IW = $clog2(FRAME_SAMPLES + 1);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_READ, S_WRITE, S_HDR, S_PNUM, S_SRD, S_SWAIT, S_SDIV,
        S_SOUT, S_AX, S_BAT, S_LEAD, S_PIN, S_FOOT
    } state_t;

    // configuration
    logic [DIV_W-1:0] diva_reg, divb_reg;
    logic accel_en_reg, bat_en_reg, lead_en_reg, dig_en_reg;
    logic cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diva_reg     <= DIV_W'(1);
            divb_reg     <= DIV_W'(1);
            accel_en_reg <= 1'b1;
            bat_en_reg   <= 1'b0;
            lead_en_reg  <= 1'b0;
            dig_en_reg   <= 1'b0;
        end
        else if (cfg_wr)
        begin
            case (reg_idx_t'(paddr[4:2]))
                REG_ECG_A_DIV:  diva_reg     <= pwdata[DIV_W-1:0];
                REG_ECG_B_DIV:  divb_reg     <= pwdata[DIV_W-1:0];
                REG_ACCEL_EN:   accel_en_reg <= pwdata[0];
                REG_BATTERY_EN: bat_en_reg   <= pwdata[0];
                REG_LEAD_EN:    lead_en_reg  <= pwdata[0];
                REG_DIGITAL_EN: dig_en_reg   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx_t'(paddr[4:2]))
            REG_ECG_A_DIV:  prdata = 32'(diva_reg);
            REG_ECG_B_DIV:  prdata = 32'(divb_reg);
            REG_ACCEL_EN:   prdata = 32'(accel_en_reg);
            REG_BATTERY_EN: prdata = 32'(bat_en_reg);
            REG_LEAD_EN:    prdata = 32'(lead_en_reg);
            REG_DIGITAL_EN: prdata = 32'(dig_en_reg);
            default:        prdata = '0;
        endcase
    end

    // slot count: largest m with m * d inside the frame, zero when d is off
    function automatic logic [IW:0] slots_of(input logic [DIV_W-1:0] d);
        logic [IW:0] n;
        n = '0;
        for (int k = 1; k <= 31; k++)
        begin
            for (int m = 1; m <= 16; m++)
            begin
                if (d == DIV_W'(k) && m * k <= FRAME_SAMPLES)
                begin
                    n = (IW+1)'(m);
                end
            end
        end
        return n;
    endfunction

    state_t state_reg;
    logic [IW-1:0] idx_reg;
    logic [15:0]   pnum_reg;
    logic [15:0]   axs_reg [3];
    logic [15:0]   bsum_reg;
    logic [15:0]   pins_reg;
    logic signed [23:0] sa_reg, sb_reg;
    logic [7:0]    lead_reg;
    logic          a_first_reg, b_first_reg, a_use_reg, b_use_reg;
    logic [AW-1:0] a_slot_reg, b_slot_reg;
    logic          chan_reg;
    logic [IW:0]   oslot_reg;
    logic [23:0]   chunk_reg;
    logic [1:0]    bytes_reg;
    logic          last_reg, ovalid_reg;
    logic [1:0]    axi_reg;

    // slot of idx under divider d, plus whether it is a slot start
    logic [IW:0] na, nb;
    logic [AW-1:0] qa, qb;
    logic ra, rb, ua, ub;
    assign na = slots_of(diva_reg);
    assign nb = slots_of(divb_reg);
    always_comb
    begin
        qa = '0; ra = 1'b0; qb = '0; rb = 1'b0;
        // slot = largest m with m * d <= idx; a slot starts on a multiple of d
        for (int k = 1; k <= 16; k++)
        begin
            for (int m = 0; m < 16; m++)
            begin
                if (diva_reg == DIV_W'(k) && m * k <= int'(idx_reg))
                begin
                    qa = AW'(m);
                end
                if (diva_reg == DIV_W'(k) && m * k == int'(idx_reg))
                begin
                    ra = 1'b1;
                end
                if (divb_reg == DIV_W'(k) && m * k <= int'(idx_reg))
                begin
                    qb = AW'(m);
                end
                if (divb_reg == DIV_W'(k) && m * k == int'(idx_reg))
                begin
                    rb = 1'b1;
                end
            end
        end
        ua = (na != '0) && ((IW+1)'(qa) < na);
        ub = (nb != '0) && ((IW+1)'(qb) < nb);
    end

    // slot memories
    logic             wea, web;
    logic [AW-1:0]    addra, addrb;
    logic [SUM_W-1:0] wda, wdb, rda, rdb;
    assign wea = ((state_reg == S_WRITE) && a_use_reg) || (state_reg == S_CLEAR);
    assign web = ((state_reg == S_WRITE) && b_use_reg) || (state_reg == S_CLEAR);
    assign addra = (state_reg == S_WRITE || state_reg == S_READ) ? a_slot_reg
                                                               : AW'(oslot_reg);
    assign addrb = (state_reg == S_WRITE || state_reg == S_READ) ? b_slot_reg
                                                               : AW'(oslot_reg);
    assign wda = (state_reg == S_CLEAR) ? '0 :
                 a_first_reg ? SUM_W'(sa_reg) : SUM_W'(rda + SUM_W'(sa_reg));
    assign wdb = (state_reg == S_CLEAR) ? '0 :
                 b_first_reg ? SUM_W'(sb_reg) : SUM_W'(rdb + SUM_W'(sb_reg));

    dsp_ram #(.WIDTH(SUM_W), .DEPTH(FRAME_SAMPLES)) u_ram_a (
        .clk(clk), .we(wea), .addr(addra), .wdata(wda), .rdata(rda));
    dsp_ram #(.WIDTH(SUM_W), .DEPTH(FRAME_SAMPLES)) u_ram_b (
        .clk(clk), .we(web), .addr(addrb), .wdata(wdb), .rdata(rdb));

    div_req_t dreq;
    div_rsp_t drsp;
    assign dreq.start    = (state_reg == S_SWAIT);
    assign dreq.dividend = chan_reg ? rdb : rda;
    assign dreq.divisor  = chan_reg ? divb_reg : diva_reg;
    dsp_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    logic in_acc, out_acc, frame_end;
    assign in_ready    = (state_reg == S_IDLE);
    assign in_acc      = in_valid && in_ready;
    assign out_acc     = out_valid && out_ready;
    assign out_valid   = ovalid_reg;
    assign chunk       = chunk_reg;
    assign chunk_bytes = bytes_reg;
    assign last        = last_reg;
    assign frame_end   = (32'(idx_reg) + 1) >= FRAME_SAMPLES;

    // a new chunk goes into the output register this cycle
    logic chunk_load;
    always_comb
    begin
        case (state_reg)
            S_HDR, S_PNUM, S_SOUT, S_FOOT: chunk_load = !ovalid_reg || out_acc;
            S_AX:    chunk_load = accel_en_reg && (!ovalid_reg || out_acc);
            S_BAT:   chunk_load = bat_en_reg && (!ovalid_reg || out_acc);
            S_LEAD:  chunk_load = lead_en_reg && (!ovalid_reg || out_acc);
            S_PIN:   chunk_load = dig_en_reg && (!ovalid_reg || out_acc);
            default: chunk_load = 1'b0;
        endcase
    end

    logic [IW:0] cur_n;
    assign cur_n = chan_reg ? nb : na;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            idx_reg    <= '0;
            pnum_reg   <= '0;
            pins_reg   <= '0;
            ovalid_reg <= 1'b0;
            chan_reg   <= 1'b0;
            oslot_reg  <= '0;
            axi_reg    <= '0;
            for (int k = 0; k < 3; k++)
            begin
                axs_reg[k] <= '0;
            end
            bsum_reg   <= '0;
        end
        else
        begin
            if (out_acc && !chunk_load)
            begin
                ovalid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    if (32'(oslot_reg) + 1 >= FRAME_SAMPLES)
                    begin
                        oslot_reg <= '0;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        oslot_reg <= oslot_reg + (IW+1)'(1);
                    end
                end
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        sa_reg      <= ecg_a;
                        sb_reg      <= ecg_b;
                        lead_reg    <= lead_off_status;
                        a_slot_reg  <= qa;
                        b_slot_reg  <= qb;
                        a_first_reg <= ra;
                        b_first_reg <= rb;
                        a_use_reg   <= ua;
                        b_use_reg   <= ub;
                        if (idx_reg == '0)
                        begin
                            axs_reg[0] <= accel_x;
                            axs_reg[1] <= accel_y;
                            axs_reg[2] <= accel_z;
                            bsum_reg   <= battery;
                        end
                        else
                        begin
                            axs_reg[0] <= axs_reg[0] + accel_x;
                            axs_reg[1] <= axs_reg[1] + accel_y;
                            axs_reg[2] <= axs_reg[2] + accel_z;
                            bsum_reg   <= bsum_reg + battery;
                        end
                        if (idx_reg == '0)
                        begin
                            pins_reg <= 16'((dig_en_reg && pin_level) ? 1 : 0);
                        end
                        else if (dig_en_reg && pin_level && 32'(idx_reg) < 16)
                        begin
                            pins_reg[4'(idx_reg)] <= 1'b1;
                        end
                        state_reg <= S_READ;
                    end
                end
                S_READ:  state_reg <= S_WRITE;
                S_WRITE:
                begin
                    if (frame_end)
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_HDR;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + IW'(1);
                        state_reg <= S_IDLE;
                    end
                end
                S_HDR:
                begin
                    if (!ovalid_reg || out_acc)
                    begin
                        chunk_reg  <= 24'(HEADER_WORD);
                        bytes_reg  <= 2'd2;
                        last_reg   <= 1'b0;
                        ovalid_reg <= 1'b1;
                        state_reg  <= S_PNUM;
                    end
                end
                S_PNUM:
                begin
                    if (!ovalid_reg || out_acc)
                    begin
                        chunk_reg  <= 24'(pnum_reg);
                        bytes_reg  <= 2'd2;
                        last_reg   <= 1'b0;
                        ovalid_reg <= 1'b1;
                        pnum_reg   <= pnum_reg + 16'd1;
                        chan_reg   <= 1'b0;
                        oslot_reg  <= '0;
                        state_reg  <= S_SRD;
                    end
                end
                S_SRD:
                begin
                    if (oslot_reg >= cur_n)
                    begin
                        oslot_reg <= '0;
                        if (!chan_reg)
                        begin
                            chan_reg <= 1'b1;
                        end
                        else
                        begin
                            axi_reg   <= '0;
                            state_reg <= S_AX;
                        end
                    end
                    else
                    begin
                        state_reg <= S_SWAIT;
                    end
                end
                S_SWAIT: state_reg <= S_SDIV;
                S_SDIV:
                begin
                    if (drsp.done)
                    begin
                        state_reg <= S_SOUT;
                    end
                end
                S_SOUT:
                begin
                    if (!ovalid_reg || out_acc)
                    begin
                        chunk_reg  <= drsp.quotient;
                        bytes_reg  <= 2'd3;
                        last_reg   <= 1'b0;
                        ovalid_reg <= 1'b1;
                        oslot_reg  <= oslot_reg + (IW+1)'(1);
                        state_reg  <= S_SRD;
                    end
                end
                S_AX:
                begin
                    if (!accel_en_reg)
                    begin
                        state_reg <= S_BAT;
                    end
                    else if (!ovalid_reg || out_acc)
                    begin
                        chunk_reg  <= 24'(axs_reg[axi_reg]);
                        bytes_reg  <= 2'd2;
                        last_reg   <= 1'b0;
                        ovalid_reg <= 1'b1;
                        axi_reg    <= axi_reg + 2'd1;
                        if (axi_reg == 2'd2)
                        begin
                            state_reg <= S_BAT;
                        end
                    end
                end
                S_BAT:
                begin
                    if (!bat_en_reg)
                    begin
                        state_reg <= S_LEAD;
                    end
                    else if (!ovalid_reg || out_acc)
                    begin
                        chunk_reg  <= 24'(bsum_reg);
                        bytes_reg  <= 2'd2;
                        last_reg   <= 1'b0;
                        ovalid_reg <= 1'b1;
                        state_reg  <= S_LEAD;
                    end
                end
                S_LEAD:
                begin
                    if (!lead_en_reg)
                    begin
                        state_reg <= S_PIN;
                    end
                    else if (!ovalid_reg || out_acc)
                    begin
                        chunk_reg  <= 24'(lead_reg);
                        bytes_reg  <= 2'd1;
                        last_reg   <= 1'b0;
                        ovalid_reg <= 1'b1;
                        state_reg  <= S_PIN;
                    end
                end
                S_PIN:
                begin
                    if (!dig_en_reg)
                    begin
                        state_reg <= S_FOOT;
                    end
                    else if (!ovalid_reg || out_acc)
                    begin
                        chunk_reg  <= 24'(pins_reg);
                        bytes_reg  <= 2'd2;
                        last_reg   <= 1'b0;
                        ovalid_reg <= 1'b1;
                        state_reg  <= S_FOOT;
                    end
                end
                S_FOOT:
                begin
                    if (!ovalid_reg || out_acc)
                    begin
                        chunk_reg  <= 24'(FOOTER_BYTE);
                        bytes_reg  <= 2'd1;
                        last_reg   <= 1'b1;
                        ovalid_reg <= 1'b1;
                        state_reg  <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // the RAMs are only written in the clearing pass and the write-back step
    a_wr_only_in_write: assert property (@(posedge clk) disable iff (!rst_n)
        (wea || web) |-> (state_reg == S_WRITE || state_reg == S_CLEAR))
        else $error("slot RAM written outside write-back");
    // a divide started always finishes before the chunk is sent
    div_done_before_out: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SOUT |-> $past(drsp.done) || $past(state_reg == S_SOUT))
        else $error("slot chunk without divider result");
    // the sample counter stays inside the frame
    idx_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        32'(idx_reg) < FRAME_SAMPLES)
        else $error("sample index out of frame");

endmodule
